// File: hw/rtl/gdfw_pkg.sv
// shared constants and types of the depth-first graph walk unit
package gdfw_pkg;

  localparam int MAX_NODES_DEF  = 64;
  localparam int MAX_DEGREE_DEF = 16;

  localparam int NODE_W   = 6;
  localparam int CNT_W    = 7;
  localparam int TDATA_IN_W  = 24;
  localparam int TDATA_OUT_W = 8;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_WALK     = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_START = 1'b1;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_UNDIRECTED = 1'b1;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_EDGE_DEG = 10'b00_0000_0010,
    S_EDGE_WR  = 10'b00_0000_0100,
    S_REV_DEG  = 10'b00_0000_1000,
    S_REV_WR   = 10'b00_0001_0000,
    S_DEG      = 10'b00_0010_0000,
    S_LOOK     = 10'b00_0100_0000,
    S_NBR      = 10'b00_1000_0000,
    S_POP      = 10'b01_0000_0000,
    S_FIN      = 10'b10_0000_0000
  } state_t;

endpackage

// File: hw/rtl/gdfw_ram.sv
// generic single-write, single-read ram with registered read data
module gdfw_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                        wdata,
  input  logic                                re,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                        rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/graph_depth_first_walk_unit.sv
// depth-first graph walk unit: adjacency list build and preorder walk
//
// An input word with tuser 0 adds the edge src->dst (and dst->src when
// undirected_mode is set) to the adjacency list; it gives no output word.
// The edge is dropped if src or dst is at or above node_count; a full
// neighbor list drops its direction. A word with tuser 1 starts a walk
// from start_node: the visited map is cleared and every reached node comes
// out once in depth-first preorder, tlast on the final one. A start node at
// or above node_count gives a single word with node 0, tuser 1 and tlast.
// The walk runs on one sequencer sharing the neighbor, degree and stack
// memories, each with one read port: every stored neighbor of a reached node
// is addressed, then checked against the visited map, and every reached
// node adds its degree read, its final look and the pop back to its parent
// (the start node ends the walk there instead). Output words are held in an
// output register; the walk stalls only while that register is full. No new
// input word is taken until the current one is done.
module graph_depth_first_walk_unit
  import gdfw_pkg::*;
#(
  parameter int MAX_NODES  = MAX_NODES_DEF,
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input word stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // src_node, dst_node, start_node, zero pad
  input  logic                   s_axis_tuser,   // op
  // output word stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // node_id, zero pad
  output logic                   m_axis_tlast,
  output logic                   m_axis_tuser,   // status
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int NIW  = $clog2(MAX_NODES);
  localparam int DGW  = $clog2(MAX_DEGREE + 1);
  localparam int NBD  = MAX_NODES * MAX_DEGREE;
  localparam int NAW  = (NBD > 1) ? $clog2(NBD) : 1;
  localparam int SAW  = NIW;
  localparam int SDW  = $clog2(MAX_NODES + 1);
  localparam int STKW = NODE_W + DGW;

  // configuration registers
  logic [CNT_W-1:0] node_count;
  logic             undirected_mode;
  logic             cfg_wr;
  logic [CNT_W-1:0] eff_count;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count      <= NODE_COUNT_RST;
      undirected_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_NODE_COUNT: node_count      <= pwdata[CNT_W-1:0];
        REG_UNDIRECTED: undirected_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NODE_COUNT: prdata = {{(APB_DW-CNT_W){1'b0}}, node_count};
      REG_UNDIRECTED: prdata = {{(APB_DW-1){1'b0}}, undirected_mode};
      default:        prdata = '0;
    endcase
  end

  assign eff_count = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;

  // input fields
  logic              in_op;
  logic [NODE_W-1:0] in_src;
  logic [NODE_W-1:0] in_dst;
  logic [NODE_W-1:0] in_start;
  logic              in_acc;

  assign in_op    = s_axis_tuser;
  assign in_src   = s_axis_tdata[NODE_W-1:0];
  assign in_dst   = s_axis_tdata[2*NODE_W-1:NODE_W];
  assign in_start = s_axis_tdata[3*NODE_W-1:2*NODE_W];

  // sequencer registers
  state_t            state, state_next;
  logic [NODE_W-1:0] e_src, e_dst;
  logic [NODE_W-1:0] top_node;
  logic [DGW-1:0]    top_pos;
  logic [SDW-1:0]    depth;
  logic [NODE_W-1:0] pend_node;
  logic              pend_status;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] deg_valid;
  logic              deg_vld_q;

  // memory ports
  logic              deg_we, deg_re;
  logic [NIW-1:0]    deg_waddr, deg_raddr;
  logic [DGW-1:0]    deg_wdata, deg_q, deg_val;
  logic              nbr_we, nbr_re;
  logic [NAW-1:0]    nbr_waddr, nbr_raddr;
  logic [NODE_W-1:0] nbr_wdata, nbr_q;
  logic              stk_we, stk_re;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  logic [STKW-1:0]   stk_wdata, stk_q;

  // edge append and walk decisions
  logic [NODE_W-1:0] app_from, app_to;
  logic              app_ok;
  logic              out_free;
  logic              has_nbr;
  logic              nbr_new;
  logic              out_load;
  logic              out_last;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign deg_val  = deg_vld_q ? deg_q : '0;
  assign app_from = (state == S_REV_WR) ? e_dst : e_src;
  assign app_to   = (state == S_REV_WR) ? e_src : e_dst;
  assign app_ok   = deg_val < DGW'(MAX_DEGREE);
  assign has_nbr  = top_pos < deg_val;
  assign nbr_new  = !visited[nbr_q[NIW-1:0]];

  // degree memory: read for append and for each node on top of the stack
  assign deg_re    = (state == S_EDGE_DEG) || (state == S_REV_DEG) || (state == S_DEG);
  assign deg_raddr = (state == S_EDGE_DEG) ? e_src[NIW-1:0] :
                     (state == S_REV_DEG)  ? e_dst[NIW-1:0] : top_node[NIW-1:0];
  assign deg_we    = ((state == S_EDGE_WR) || (state == S_REV_WR)) && app_ok;
  assign deg_waddr = app_from[NIW-1:0];
  assign deg_wdata = deg_val + DGW'(1);

  assign nbr_we    = deg_we;
  assign nbr_waddr = NAW'(app_from[NIW-1:0]) * NAW'(MAX_DEGREE) + NAW'(deg_val);
  assign nbr_wdata = app_to;
  assign nbr_re    = (state == S_LOOK) && has_nbr;
  assign nbr_raddr = NAW'(top_node[NIW-1:0]) * NAW'(MAX_DEGREE) + NAW'(top_pos);

  // stack memory holds the entries below the top, which lives in registers
  assign stk_we    = (state == S_NBR) && nbr_new && out_free;
  assign stk_waddr = SAW'(depth - SDW'(1));
  assign stk_wdata = {top_node, top_pos};
  assign stk_re    = (state == S_LOOK) && !has_nbr && (depth != SDW'(1));
  assign stk_raddr = SAW'(depth - SDW'(2));

  assign out_load = ((state == S_NBR) && nbr_new && out_free) ||
                    ((state == S_FIN) && out_free);
  assign out_last = (state == S_FIN);

  gdfw_ram #(.W(DGW), .D(MAX_NODES)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .re    (deg_re),
    .raddr (deg_raddr),
    .rdata (deg_q)
  );

  gdfw_ram #(.W(NODE_W), .D(NBD)) u_nbr_ram (
    .clk   (clk),
    .we    (nbr_we),
    .waddr (nbr_waddr),
    .wdata (nbr_wdata),
    .re    (nbr_re),
    .raddr (nbr_raddr),
    .rdata (nbr_q)
  );

  gdfw_ram #(.W(STKW), .D(MAX_NODES)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_WALK) begin
            state_next = ({1'b0, in_start} < eff_count) ? S_DEG : S_FIN;
          end else if (({1'b0, in_src} < eff_count) && ({1'b0, in_dst} < eff_count)) begin
            state_next = S_EDGE_DEG;
          end
        end
      end
      S_EDGE_DEG: state_next = S_EDGE_WR;
      S_EDGE_WR:  state_next = undirected_mode ? S_REV_DEG : S_IDLE;
      S_REV_DEG:  state_next = S_REV_WR;
      S_REV_WR:   state_next = S_IDLE;
      S_DEG:      state_next = S_LOOK;
      S_LOOK: begin
        if (has_nbr) begin
          state_next = S_NBR;
        end else if (depth == SDW'(1)) begin
          state_next = S_FIN;
        end else begin
          state_next = S_POP;
        end
      end
      S_NBR: begin
        if (!nbr_new) begin
          state_next = S_LOOK;
        end else if (out_free) begin
          state_next = S_DEG;
        end
      end
      S_POP:      state_next = S_DEG;
      S_FIN:      state_next = out_free ? S_IDLE : S_FIN;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      deg_valid <= '0;
      visited   <= '0;
      depth     <= '0;
    end else begin
      state <= state_next;
      if (deg_we) begin
        deg_valid[deg_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && (in_op == OP_WALK)) begin
            // clear the map and mark the start node in one go
            if ({1'b0, in_start} < eff_count) begin
              visited <= MAX_NODES'(1) << in_start[NIW-1:0];
              depth   <= SDW'(1);
            end else begin
              visited <= '0;
              depth   <= '0;
            end
          end
        end
        S_LOOK: begin
          if (!has_nbr) begin
            depth <= depth - SDW'(1);
          end
        end
        S_NBR: begin
          if (nbr_new && out_free) begin
            visited[nbr_q[NIW-1:0]] <= 1'b1;
            depth                   <= depth + SDW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers of the walk
  always_ff @(posedge clk) begin
    if (deg_re) begin
      deg_vld_q <= deg_valid[deg_raddr];
    end
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          e_src    <= in_src;
          e_dst    <= in_dst;
          top_node <= in_start;
          top_pos  <= '0;
          if ({1'b0, in_start} < eff_count) begin
            pend_node   <= in_start;
            pend_status <= STATUS_OK;
          end else begin
            pend_node   <= '0;
            pend_status <= STATUS_BAD_START;
          end
        end
      end
      S_LOOK: begin
        if (has_nbr) begin
          top_pos <= top_pos + DGW'(1);
        end
      end
      S_NBR: begin
        if (nbr_new && out_free) begin
          pend_node <= nbr_q;
          top_node  <= nbr_q;
          top_pos   <= '0;
        end
      end
      S_POP: begin
        top_node <= stk_q[STKW-1:DGW];
        top_pos  <= stk_q[DGW-1:0];
      end
      default: ;
    endcase
  end

  // output register: a node goes out once the next one is found or the walk ends
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {{(TDATA_OUT_W-NODE_W){1'b0}}, pend_node};
      m_axis_tlast <= out_last;
      m_axis_tuser <= pend_status;
    end
  end

endmodule

// File: tb/gdfw_walk_checker.sv
// checker for the depth-first walk unit: tracks config writes, predicts walk order, compares words
`timescale 1ns / 1ps

module gdfw_walk_checker
  import gdfw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // src_node, dst_node, start_node, zero pad
  input  logic                   s_axis_tuser,   // op
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [TDATA_OUT_W-1:0] m_axis_tdata,   // node_id, zero pad
  input  logic                   m_axis_tlast,
  input  logic                   m_axis_tuser,   // status
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  input  logic                   pready,
  output int                     fail_count,
  output int                     pending
);

  localparam logic [APB_AW-1:0] ADDR_NODE_COUNT = {REG_NODE_COUNT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNDIRECTED = {REG_UNDIRECTED, 2'b00};

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic              last;
    logic              status;
  } visit_t;

  visit_t            visit_q[$];
  logic [NODE_W-1:0] adj_list [MAX_NODES_DEF][MAX_DEGREE_DEF];
  int unsigned       degree [MAX_NODES_DEF];
  logic [CNT_W-1:0]  node_count;
  logic              undirected;
  int                mismatches = 0;

  function automatic int unsigned live_nodes();
    return (node_count > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(node_count);
  endfunction

  task automatic append_neighbor(int unsigned from, int unsigned to);
    if (degree[from] < MAX_DEGREE_DEF) begin
      adj_list[from][degree[from]] = to[NODE_W-1:0];
      degree[from]++;
    end
  endtask

  task automatic store_edge(int unsigned src, int unsigned dst);
    int unsigned n;
    n = live_nodes();
    if (src < n && dst < n) begin
      append_neighbor(src, dst);
      if (undirected) append_neighbor(dst, src);
    end
  endtask

  task automatic queue_visit(int unsigned node, logic status);
    visit_t item;
    item.node_id = node[NODE_W-1:0];
    item.last    = 1'b0;
    item.status  = status;
    visit_q      = {visit_q, item};
  endtask

  task automatic predict_walk(int unsigned start);
    bit          seen [MAX_NODES_DEF];
    int unsigned path_node [MAX_NODES_DEF];
    int unsigned path_pos [MAX_NODES_DEF];
    int unsigned depth;
    int unsigned top;
    int unsigned node;
    int unsigned nb;
    int unsigned found;
    if (start >= live_nodes()) begin
      queue_visit(0, STATUS_BAD_START);
      visit_q[visit_q.size()-1].last = 1'b1;
      return;
    end
    foreach (seen[i]) seen[i] = 1'b0;
    seen[start] = 1'b1;
    queue_visit(start, STATUS_OK);
    found        = 1;
    path_node[0] = start;
    path_pos[0]  = 0;
    depth        = 1;
    while (depth > 0) begin
      top  = depth - 1;
      node = path_node[top];
      if (path_pos[top] < degree[node]) begin
        nb = adj_list[node][path_pos[top]];
        path_pos[top]++;
        if (!seen[nb] && depth < MAX_NODES_DEF && found < MAX_NODES_DEF) begin
          seen[nb] = 1'b1;
          queue_visit(nb, STATUS_OK);
          found++;
          path_node[depth] = nb;
          path_pos[depth]  = 0;
          depth++;
        end
      end else begin
        depth--;
      end
    end
    visit_q[visit_q.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    visit_t v;
    if (rst) begin
      foreach (degree[i]) degree[i] = 0;
      node_count = NODE_COUNT_RST;
      undirected = 1'b0;
      visit_q.delete();
    end else begin
      // outputs first: a finished walk's word may leave as the next input word enters
      if (m_axis_tvalid && m_axis_tready) begin
        if (visit_q.size() == 0) begin
          $display("%0t: unexpected word node_id=%0d last=%0b status=%0b", $time,
                   m_axis_tdata[NODE_W-1:0], m_axis_tlast, m_axis_tuser);
          mismatches++;
        end else begin
          v = visit_q.pop_front();
          if (m_axis_tdata[NODE_W-1:0] !== v.node_id || m_axis_tlast !== v.last ||
              m_axis_tuser !== v.status) begin
            $display("%0t: exp node=%0d last=%0b st=%0b, got node=%0d last=%0b st=%0b",
                     $time, v.node_id, v.last, v.status,
                     m_axis_tdata[NODE_W-1:0], m_axis_tlast, m_axis_tuser);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_ADD_EDGE)
          store_edge(s_axis_tdata[NODE_W-1:0], s_axis_tdata[2*NODE_W-1:NODE_W]);
        else
          predict_walk(s_axis_tdata[3*NODE_W-1:2*NODE_W]);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_NODE_COUNT: node_count = pwdata[CNT_W-1:0];
          ADDR_UNDIRECTED: undirected = pwdata[0];
          default: ;
        endcase
      end
    end
    pending    <= visit_q.size();
    fail_count <= mismatches;
  end

endmodule

// File: tb/tb.sv
// top of the depth-first walk unit testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
  import gdfw_pkg::*;

  localparam logic [APB_AW-1:0] ADDR_NODE_COUNT = {REG_NODE_COUNT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNDIRECTED = {REG_UNDIRECTED, 2'b00};
  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_WORDS = 42;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;   // src_node, dst_node, start_node, zero pad
  logic                   s_axis_tuser = 1'b0; // op
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;        // node_id, zero pad
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;        // status
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_AW-1:0]      paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  int fail_count;
  int pending;
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  graph_depth_first_walk_unit DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  gdfw_walk_checker walk_check (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  // ends the run when nothing moves on any port for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(logic op, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
                           logic [NODE_W-1:0] start);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(TDATA_IN_W-3*NODE_W){1'b0}}, start, dst, src};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic add_edge(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
    send_word(OP_ADD_EDGE, src, dst, NODE_W'($urandom_range(63)));
  endtask

  task automatic start_walk(logic [NODE_W-1:0] start);
    send_word(OP_WALK, NODE_W'($urandom_range(63)), NODE_W'($urandom_range(63)), start);
  endtask

  // wait out every expected word plus the tail of an edge insert
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // mostly in-range edges and walks, the rest raw noise
  task automatic random_phase(int unsigned count, logic und, int sidle, int rstall);
    int unsigned span;
    int unsigned pick;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    settle();
    apb_write(ADDR_NODE_COUNT, APB_DW'(count));
    apb_write(ADDR_UNDIRECTED, APB_DW'(und));
    send_idle  = sidle;
    recv_stall = rstall;
    span = (count > MAX_NODES_DEF) ? MAX_NODES_DEF : count;
    repeat (PHASE_WORDS) begin
      pick = $urandom_range(99);
      a = (span == 0) ? NODE_W'($urandom_range(63)) : NODE_W'($urandom_range(span - 1));
      b = (span == 0) ? NODE_W'($urandom_range(63)) : NODE_W'($urandom_range(span - 1));
      if (pick < 68) add_edge(a, b);
      else if (pick < 88) start_walk(a);
      else send_word(1'($urandom_range(1)), NODE_W'($urandom_range(63)),
                     NODE_W'($urandom_range(63)), NODE_W'($urandom_range(63)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty graph, back and cross edges, extreme nodes
    start_walk(6'd0);
    add_edge(6'd0, 6'd1);
    add_edge(6'd0, 6'd2);
    add_edge(6'd1, 6'd3);
    add_edge(6'd3, 6'd0);
    add_edge(6'd2, 6'd3);
    add_edge(6'd63, 6'd62);
    add_edge(6'd62, 6'd63);
    add_edge(6'd5, 6'd40);
    start_walk(6'd0);
    start_walk(6'd63);

    // smaller graph: dropped edges, bad starts, stale neighbor above the count
    settle();
    apb_write(ADDR_NODE_COUNT, APB_DW'(10));
    add_edge(6'd12, 6'd1);
    add_edge(6'd1, 6'd10);
    start_walk(6'd10);
    start_walk(6'd63);
    start_walk(6'd5);

    // both directions, self loop stored twice
    settle();
    apb_write(ADDR_UNDIRECTED, APB_DW'(1));
    add_edge(6'd4, 6'd4);
    add_edge(6'd6, 6'd7);
    add_edge(6'd9, 6'd6);
    start_walk(6'd7);
    start_walk(6'd4);

    random_phase(64, 1'b0, 0, 0);
    random_phase(3, 1'b1, 63, 0);
    random_phase(1, 1'b0, 0, 63);
    random_phase(0, 1'b1, 16, 16);
    random_phase(127, 1'b0, 0, 0);
    random_phase(5, 1'b1, 63, 0);
    random_phase(64, 1'b1, 0, 63);
    random_phase(40, 1'b0, 16, 16);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/gdfw_pkg.sv
hw/rtl/gdfw_ram.sv
hw/rtl/graph_depth_first_walk_unit.sv
tb/gdfw_walk_checker.sv
tb/tb.sv
